/* rtl/core/sedq_pkg.sv */
package sedq_pkg;

  localparam int BYTE_W = 8;

  // configuration register indexes
  localparam logic [1:0] REG_START_BYTE = 2'd0;
  localparam logic [1:0] REG_QUAL_BYTE  = 2'd1;
  localparam logic [1:0] REG_END_BYTE   = 2'd2;
  localparam logic [1:0] REG_MAX_LEN    = 2'd3;

  localparam int MAX_LEN_W = 6;

  // result event codes
  localparam logic [1:0] EV_STORED  = 2'd0;
  localparam logic [1:0] EV_DROPPED = 2'd1;
  localparam logic [1:0] EV_DATA    = 2'd2;
  localparam logic [1:0] EV_EMPTY   = 2'd3;

  // request kinds
  localparam logic KIND_RX_BYTE = 1'b0;
  localparam logic KIND_FETCH   = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COPY,
    S_FRD,
    S_FOUT
  } seq_state_t;

  typedef enum logic [2:0] {
    P_HUNT,
    P_QUAL,
    P_LEN,
    P_CMD,
    P_DATA
  } parse_state_t;

endpackage

/* rtl/core/stx_etx_packet_deframer_queue.sv */
// A received byte that does not close a frame gives no result.
// A closing byte that stores a frame first copies its N data bytes into a queue slot before the result;
// a dropped frame or an empty fetch shows its result the cycle after the request.
// A fetch reads each data byte (S_FRD) and then shows it (S_FOUT) until out_stall is low; one request at a time.
// Reset (rst_n low, synchronous) clears the parser, queue pointers, packet count and
// restores the configuration defaults; queue and assembly memories are not cleared.
module stx_etx_packet_deframer_queue #(
  parameter int MAX_DATA_BYTES = 32,
  parameter int QUEUE_DEPTH    = 16,
  localparam int IW = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1,
  localparam int LW = $clog2(MAX_DATA_BYTES + 1),
  localparam int CW = $clog2(QUEUE_DEPTH + 1),
  localparam int PW = $clog2(QUEUE_DEPTH)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // request channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_kind,
  input  logic [sedq_pkg::BYTE_W-1:0] in_rx_byte,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_event_res,
  output logic [sedq_pkg::BYTE_W-1:0] out_command,
  output logic [LW-1:0]             out_data_len,
  output logic [IW-1:0]             out_byte_index,
  output logic [sedq_pkg::BYTE_W-1:0] out_data_byte,
  output logic [CW-1:0]             out_queue_count,
  output logic                      out_last,
  // configuration write port
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [sedq_pkg::BYTE_W-1:0] cfg_wdata
);

  localparam int QW = PW + IW;  // queue data address: {slot, byte index}

  // configuration registers
  logic [sedq_pkg::BYTE_W-1:0]    cfg_start_r, cfg_qual_r, cfg_end_r;
  logic [sedq_pkg::MAX_LEN_W-1:0] cfg_max_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_start_r   <= 8'd2;
      cfg_qual_r    <= 8'd0;
      cfg_end_r     <= 8'd3;
      cfg_max_len_r <= 6'd32;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sedq_pkg::REG_START_BYTE: cfg_start_r <= cfg_wdata;
        sedq_pkg::REG_QUAL_BYTE:  cfg_qual_r  <= cfg_wdata;
        sedq_pkg::REG_END_BYTE:   cfg_end_r   <= cfg_wdata;
        sedq_pkg::REG_MAX_LEN:    cfg_max_len_r <= cfg_wdata[sedq_pkg::MAX_LEN_W-1:0];
      endcase
    end
  end

  // Effective length limit: the smaller of the register and the buffer size.
  logic [sedq_pkg::BYTE_W-1:0] len_limit;
  always_comb begin
    if (8'(cfg_max_len_r) > 8'(MAX_DATA_BYTES)) begin
      len_limit = 8'(MAX_DATA_BYTES);
    end else begin
      len_limit = 8'(cfg_max_len_r);
    end
  end

  // Sequencer and parser state
  sedq_pkg::seq_state_t   state_r, state_nxt;
  sedq_pkg::parse_state_t pstate_r, pstate_nxt;
  logic [LW-1:0] data_cnt_r, data_cnt_nxt;
  logic [LW-1:0] frame_len_r, frame_len_nxt;
  logic [sedq_pkg::BYTE_W-1:0] frame_cmd_r, frame_cmd_nxt;

  // Queue bookkeeping
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [sedq_pkg::BYTE_W-1:0] q_cmd_r [QUEUE_DEPTH];
  logic [LW-1:0]               q_len_r [QUEUE_DEPTH];
  logic                        meta_we;

  // Copy engine: assembly buffer to queue slot, one byte a cycle
  logic [LW-1:0] copy_idx_r, copy_idx_nxt;
  logic          wr_pend_r, wr_pend_nxt;
  logic [IW-1:0] wr_idx_r, wr_idx_nxt;

  // Fetch walker
  logic [IW-1:0] fetch_idx_r, fetch_idx_nxt;
  logic [LW-1:0] fetch_len_r, fetch_len_nxt;
  logic [PW-1:0] fetch_slot_r, fetch_slot_nxt;

  // Result register
  logic                        out_valid_r, out_valid_nxt;
  logic [1:0]                  out_event_r, out_event_nxt;
  logic [sedq_pkg::BYTE_W-1:0] out_cmd_r, out_cmd_nxt;
  logic [LW-1:0]               out_len_r, out_len_nxt;
  logic [IW-1:0]               out_idx_r, out_idx_nxt;
  logic [CW-1:0]               out_qcnt_r, out_qcnt_nxt;
  logic                        out_last_r, out_last_nxt;
  logic                        out_sel_r, out_sel_nxt;

  // Memory ports
  logic                        asm_we, asm_re;
  logic [IW-1:0]               asm_waddr, asm_raddr;
  logic [sedq_pkg::BYTE_W-1:0] asm_rdata;
  logic                        q_re;
  logic [QW-1:0]               q_raddr;
  logic [sedq_pkg::BYTE_W-1:0] q_rdata;

  logic accept;
  assign in_stall = (state_r != sedq_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    if (p == PW'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    state_nxt      = state_r;
    pstate_nxt     = pstate_r;
    data_cnt_nxt   = data_cnt_r;
    frame_len_nxt  = frame_len_r;
    frame_cmd_nxt  = frame_cmd_r;
    wptr_nxt       = wptr_r;
    rptr_nxt       = rptr_r;
    count_nxt      = count_r;
    copy_idx_nxt   = copy_idx_r;
    wr_pend_nxt    = 1'b0;
    wr_idx_nxt     = wr_idx_r;
    fetch_idx_nxt  = fetch_idx_r;
    fetch_len_nxt  = fetch_len_r;
    fetch_slot_nxt = fetch_slot_r;
    out_valid_nxt  = out_valid_r;
    out_event_nxt  = out_event_r;
    out_cmd_nxt    = out_cmd_r;
    out_len_nxt    = out_len_r;
    out_idx_nxt    = out_idx_r;
    out_qcnt_nxt   = out_qcnt_r;
    out_last_nxt   = out_last_r;
    out_sel_nxt    = out_sel_r;
    meta_we        = 1'b0;
    asm_we         = 1'b0;
    asm_waddr      = data_cnt_r[IW-1:0];
    asm_re         = 1'b0;
    asm_raddr      = copy_idx_r[IW-1:0];
    q_re           = 1'b0;
    q_raddr        = {fetch_slot_r, fetch_idx_r};

    unique case (state_r)
      sedq_pkg::S_IDLE: begin
        if (accept && in_kind == sedq_pkg::KIND_FETCH) begin
          if (count_r == '0) begin
            // empty queue: report it
            out_event_nxt = sedq_pkg::EV_EMPTY;
            out_cmd_nxt   = '0;
            out_len_nxt   = '0;
            out_idx_nxt   = '0;
            out_qcnt_nxt  = '0;
            out_last_nxt  = 1'b1;
            out_sel_nxt   = 1'b0;
            out_valid_nxt = 1'b1;
            state_nxt     = sedq_pkg::S_FOUT;
          end else begin
            // pop the oldest packet now; all its results carry the new count
            rptr_nxt       = ptr_inc(rptr_r);
            count_nxt      = count_r - 1'b1;
            fetch_slot_nxt = rptr_r;
            fetch_len_nxt  = q_len_r[rptr_r];
            fetch_idx_nxt  = '0;
            out_event_nxt  = sedq_pkg::EV_DATA;
            out_cmd_nxt    = q_cmd_r[rptr_r];
            out_len_nxt    = q_len_r[rptr_r];
            out_qcnt_nxt   = count_r - 1'b1;
            if (q_len_r[rptr_r] == '0) begin
              out_idx_nxt   = '0;
              out_last_nxt  = 1'b1;
              out_sel_nxt   = 1'b0;
              out_valid_nxt = 1'b1;
              state_nxt     = sedq_pkg::S_FOUT;
            end else begin
              state_nxt = sedq_pkg::S_FRD;
            end
          end
        end else if (accept) begin
          unique case (pstate_r)
            sedq_pkg::P_HUNT: begin
              if (in_rx_byte == cfg_start_r) begin
                pstate_nxt = sedq_pkg::P_QUAL;
              end
            end
            sedq_pkg::P_QUAL: begin
              pstate_nxt = (in_rx_byte == cfg_qual_r) ? sedq_pkg::P_LEN : sedq_pkg::P_HUNT;
            end
            sedq_pkg::P_LEN: begin
              if (in_rx_byte > len_limit) begin
                pstate_nxt = sedq_pkg::P_HUNT;
              end else begin
                frame_len_nxt = LW'(in_rx_byte);
                pstate_nxt    = sedq_pkg::P_CMD;
              end
            end
            sedq_pkg::P_CMD: begin
              frame_cmd_nxt = in_rx_byte;
              data_cnt_nxt  = '0;
              pstate_nxt    = sedq_pkg::P_DATA;
            end
            sedq_pkg::P_DATA: begin
              if (data_cnt_r == frame_len_r) begin
                // closing byte: a wrong end marker drops the frame silently
                pstate_nxt = sedq_pkg::P_HUNT;
                if (in_rx_byte == cfg_end_r) begin
                  if (count_r == CW'(QUEUE_DEPTH)) begin
                    out_event_nxt = sedq_pkg::EV_DROPPED;
                    out_cmd_nxt   = frame_cmd_r;
                    out_len_nxt   = frame_len_r;
                    out_idx_nxt   = '0;
                    out_qcnt_nxt  = count_r;
                    out_last_nxt  = 1'b1;
                    out_sel_nxt   = 1'b0;
                    out_valid_nxt = 1'b1;
                    state_nxt     = sedq_pkg::S_FOUT;
                  end else begin
                    copy_idx_nxt = '0;
                    state_nxt    = sedq_pkg::S_COPY;
                  end
                end
              end else begin
                asm_we       = 1'b1;
                data_cnt_nxt = data_cnt_r + 1'b1;
              end
            end
            default: begin
              pstate_nxt = sedq_pkg::P_HUNT;
            end
          endcase
        end
      end

      sedq_pkg::S_COPY: begin
        if (copy_idx_r != frame_len_r) begin
          asm_re       = 1'b1;
          wr_pend_nxt  = 1'b1;
          wr_idx_nxt   = copy_idx_r[IW-1:0];
          copy_idx_nxt = copy_idx_r + 1'b1;
        end else begin
          // last byte lands this cycle; commit the slot
          meta_we       = 1'b1;
          wptr_nxt      = ptr_inc(wptr_r);
          count_nxt     = count_r + 1'b1;
          out_event_nxt = sedq_pkg::EV_STORED;
          out_cmd_nxt   = frame_cmd_r;
          out_len_nxt   = frame_len_r;
          out_idx_nxt   = '0;
          out_qcnt_nxt  = count_r + 1'b1;
          out_last_nxt  = 1'b1;
          out_sel_nxt   = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = sedq_pkg::S_FOUT;
        end
      end

      sedq_pkg::S_FRD: begin
        q_re          = 1'b1;
        out_idx_nxt   = fetch_idx_r;
        out_last_nxt  = (LW'(fetch_idx_r) + 1'b1 == fetch_len_r);
        out_sel_nxt   = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = sedq_pkg::S_FOUT;
      end

      sedq_pkg::S_FOUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = sedq_pkg::S_IDLE;
          end else begin
            fetch_idx_nxt = fetch_idx_r + 1'b1;
            state_nxt     = sedq_pkg::S_FRD;
          end
        end
      end

      default: begin
        state_nxt = sedq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sedq_pkg::S_IDLE;
      pstate_r    <= sedq_pkg::P_HUNT;
      frame_len_r <= '0;
      wptr_r      <= '0;
      rptr_r      <= '0;
      count_r     <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pstate_r    <= pstate_nxt;
      frame_len_r <= frame_len_nxt;
      wptr_r      <= wptr_nxt;
      rptr_r      <= rptr_nxt;
      count_r     <= count_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    data_cnt_r   <= data_cnt_nxt;
    frame_cmd_r  <= frame_cmd_nxt;
    copy_idx_r   <= copy_idx_nxt;
    wr_idx_r     <= wr_idx_nxt;
    fetch_idx_r  <= fetch_idx_nxt;
    fetch_len_r  <= fetch_len_nxt;
    fetch_slot_r <= fetch_slot_nxt;
    out_event_r  <= out_event_nxt;
    out_cmd_r    <= out_cmd_nxt;
    out_len_r    <= out_len_nxt;
    out_idx_r    <= out_idx_nxt;
    out_qcnt_r   <= out_qcnt_nxt;
    out_sel_r    <= out_sel_nxt;
    if (meta_we) begin
      q_cmd_r[wptr_r] <= frame_cmd_r;
      q_len_r[wptr_r] <= frame_len_r;
    end
  end

  // Assembly buffer: filled as data bytes arrive, drained by the copy engine
  sedq_ram #(
    .WIDTH (sedq_pkg::BYTE_W),
    .DEPTH (MAX_DATA_BYTES)
  ) u_asm_ram (
    .clk   (clk),
    .we    (asm_we),
    .waddr (asm_waddr),
    .wdata (in_rx_byte),
    .re    (asm_re),
    .raddr (asm_raddr),
    .rdata (asm_rdata)
  );

  // Packet data store, one row of 2**IW bytes per queue slot
  sedq_ram #(
    .WIDTH (sedq_pkg::BYTE_W),
    .DEPTH (QUEUE_DEPTH * (1 << IW))
  ) u_queue_ram (
    .clk   (clk),
    .we    (wr_pend_r),
    .waddr ({wptr_r, wr_idx_r}),
    .wdata (asm_rdata),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // Read data holds while the result waits, since no read issues outside the fetch step.
  assign out_valid       = out_valid_r;
  assign out_event_res   = out_event_r;
  assign out_command     = out_cmd_r;
  assign out_data_len    = out_len_r;
  assign out_byte_index  = out_idx_r;
  assign out_data_byte   = out_sel_r ? q_rdata : '0;
  assign out_queue_count = out_qcnt_r;
  assign out_last        = out_last_r;

endmodule

/* rtl/core/sedq_ram.sv */
module sedq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/sedq_checker.sv */
module sedq_checker #(
  parameter int MAX_DATA_BYTES = 32,
  parameter int QUEUE_DEPTH    = 16,
  localparam int IW = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1,
  localparam int LW = $clog2(MAX_DATA_BYTES + 1),
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [1:0]                  out_event_res,
  input logic [sedq_pkg::BYTE_W-1:0] out_command,
  input logic [LW-1:0]               out_data_len,
  input logic [IW-1:0]               out_byte_index,
  input logic [sedq_pkg::BYTE_W-1:0] out_data_byte,
  input logic [CW-1:0]               out_queue_count,
  input logic                        out_last
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_res) &&
      $stable(out_command) && $stable(out_data_byte) && $stable(out_byte_index) &&
      $stable(out_last))
    else $error("stalled result changed");

  // no new request while a result is pending
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request accepted while result pending");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == sedq_pkg::EV_EMPTY |->
      out_queue_count == '0 && out_last && out_data_len == '0)
    else $error("bad empty report");

  a_frame_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == sedq_pkg::EV_STORED ||
                  out_event_res == sedq_pkg::EV_DROPPED) |->
      out_last && out_byte_index == '0 && out_data_byte == '0)
    else $error("bad frame result");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == sedq_pkg::EV_DROPPED |->
      out_queue_count == CW'(QUEUE_DEPTH))
    else $error("frame dropped with room in queue");

endmodule

bind stx_etx_packet_deframer_queue sedq_checker #(
  .MAX_DATA_BYTES (MAX_DATA_BYTES),
  .QUEUE_DEPTH    (QUEUE_DEPTH)
) u_sedq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_event_res   (out_event_res),
  .out_command     (out_command),
  .out_data_len    (out_data_len),
  .out_byte_index  (out_byte_index),
  .out_data_byte   (out_data_byte),
  .out_queue_count (out_queue_count),
  .out_last        (out_last)
);
